// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the tokenizer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ekt_pkg.sv =====
// ----------------------------------------------------------------------------
// ekt_pkg
// Types and constants shared by the entity key/value tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ekt_pkg;

   localparam int unsigned LenWidth = 9;
   localparam logic [LenWidth-1:0] MaxLenReset = 9'd256;

   localparam logic [7:0] CharQuote = 8'h22;
   localparam logic [7:0] CharOpen  = 8'h7B;
   localparam logic [7:0] CharClose = 8'h7D;
   localparam logic [7:0] CharSpace = 8'h20;

   typedef enum logic [2:0] {
      PH_WAIT_OPEN = 3'd0,
      PH_IN_ENTITY = 3'd1,
      PH_KEY       = 3'd2,
      PH_VAL_START = 3'd3,
      PH_VAL       = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      TK_SKIP     = 3'd0,
      TK_OPEN     = 3'd1,
      TK_KEY_CHAR = 3'd2,
      TK_KEY_END  = 3'd3,
      TK_VAL_CHAR = 3'd4,
      TK_PAIR_END = 3'd5,
      TK_CLOSE    = 3'd6,
      TK_ERROR    = 3'd7
   } token_kind_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [7:0]     char_out;
      logic [7:0]     char_position;
      logic           buffer_done;
      logic           buffer_ok;
   } rsp_item_type;

   typedef struct packed {
      phase_type            phase;
      logic [LenWidth-1:0]  length;
      logic                 error;
   } parse_status_type;

endpackage

// ===== rtl/entity_keypair_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// entity_keypair_tokenizer_unit
// Streaming tokenizer for entity text of the form { "key" "value" ... }.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one text byte and a flag that
// marks the last byte of a buffer. Each byte yields exactly one transfer on
// the rsp_ channel with its token kind, the string character and its
// position, and on the last byte the buffer completion and success flags.
// The csr_ port sets the string length limit; the user must write it only while idle, which the block does not enforce.
// A byte is captured in an input register, decoded combinationally against the
// parse state and placed in the result register. One byte is taken per cycle
// while the result register can drain; the parse state is updated as each
// byte is loaded into the result register.
// While rsp_stall is high the result register holds its token and the
// input register can still take one more byte before req_stall rises.
// Synchronous reset empties both registers, returns the parser to waiting
// for an entity open and sets the length limit to MAX_LEN_RESET, 256 by default.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module entity_keypair_tokenizer_unit
   import ekt_pkg::*;
#(
   parameter logic [LenWidth-1:0] MAX_LEN_RESET = MaxLenReset
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data,
   input  logic                 csr_write,
   input  logic [LenWidth-1:0]  csr_data
);

   logic [LenWidth-1:0] max_len_ff;
   logic                in_valid_ff;
   req_item_type        in_data_ff;
   logic                out_ready;
   logic                step;
   rsp_item_type        step_result;
   parse_status_type    status;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write) begin
         max_len_ff <= csr_data;
      end
   end

   assign step      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   ekt_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (in_data_ff),
      .max_len (max_len_ff),
      .result  (step_result),
      .status  (status)
   );

   ekt_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_data  (step_result),
      .load_ready (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   `ASSERT_SAME(a_ok_needs_done, clock, reset, rsp_valid && rsp_data.buffer_ok, rsp_data.buffer_done)
   `ASSERT_SAME(a_error_no_char, clock, reset, rsp_valid && (rsp_data.token_kind == TK_ERROR), (rsp_data.char_out == 8'd0) && (rsp_data.char_position == 8'd0))
   `ASSERT_NEXT(a_last_clears, clock, reset, step && in_data_ff.last_byte, (status.phase == PH_WAIT_OPEN) && (status.length == '0) && !status.error)
   `ASSERT_NEXT(a_error_sticky, clock, reset, step && status.error && !in_data_ff.last_byte, status.error)

endmodule

// ===== rtl/ekt_parser.sv =====
// ----------------------------------------------------------------------------
// ekt_parser
// Parse state registers and the combinational token decision for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ekt_parser
   import ekt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  req_item_type         item,
   input  logic [LenWidth-1:0]  max_len,
   output rsp_item_type         result,
   output parse_status_type     status
);

   phase_type           phase_ff, phase_in;
   logic [LenWidth-1:0] length_ff, length_in;
   logic                error_ff, error_in;

   always_comb begin
      logic [7:0] b;
      logic       err;
      b        = item.byte_in;
      err      = error_ff;
      phase_in = phase_ff;
      length_in = length_ff;
      result   = '0;
      result.token_kind = TK_SKIP;

      if (!error_ff) begin
         unique case (phase_ff)
            PH_IN_ENTITY: begin
               if (b <= CharSpace) begin
                  result.token_kind = TK_SKIP;
               end else if (b == CharClose) begin
                  result.token_kind = TK_CLOSE;
                  phase_in = PH_WAIT_OPEN;
               end else if (b == CharQuote) begin
                  length_in = '0;
                  phase_in  = PH_KEY;
               end else begin
                  err = 1'b1;
               end
            end
            PH_KEY, PH_VAL: begin
               if (b == CharQuote) begin
                  result.token_kind = (phase_ff == PH_KEY) ? TK_KEY_END : TK_PAIR_END;
                  length_in = '0;
                  phase_in  = (phase_ff == PH_KEY) ? PH_VAL_START : PH_IN_ENTITY;
               end else if (length_ff >= max_len) begin
                  err = 1'b1;
               end else begin
                  result.token_kind    = (phase_ff == PH_KEY) ? TK_KEY_CHAR : TK_VAL_CHAR;
                  result.char_out      = b;
                  result.char_position = length_ff[7:0];
                  length_in            = length_ff + 1'b1;
               end
            end
            PH_VAL_START: begin
               if (b == CharQuote) begin
                  length_in = '0;
                  phase_in  = PH_VAL;
               end else if (b > CharSpace) begin
                  err = 1'b1;
               end
            end
            default: begin
               if (b == CharOpen) begin
                  result.token_kind = TK_OPEN;
                  phase_in = PH_IN_ENTITY;
               end else if (b > CharSpace) begin
                  err = 1'b1;
               end
            end
         endcase
      end

      if (err) begin
         result.token_kind    = TK_ERROR;
         result.char_out      = '0;
         result.char_position = '0;
      end
      result.buffer_done = item.last_byte;
      result.buffer_ok   = item.last_byte & ~err;
      error_in = err;

      if (item.last_byte) begin
         phase_in  = PH_WAIT_OPEN;
         length_in = '0;
         error_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_OPEN;
         length_ff <= '0;
         error_ff  <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         error_ff  <= error_in;
      end
   end

   assign status.phase  = phase_ff;
   assign status.length = length_ff;
   assign status.error  = error_ff;

endmodule

// ===== rtl/ekt_out_stage.sv =====
// ----------------------------------------------------------------------------
// ekt_out_stage
// Result register that holds a token until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ekt_out_stage
   import ekt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load_valid,
   input  rsp_item_type load_data,
   output logic         load_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic         valid_ff;
   rsp_item_type data_ff;

   assign load_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ready) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
